FILE: rtl/core/tcgr_pkg.sv
package tcgr_pkg;

  localparam int GLYPH_COUNT_DEF = 256;
  localparam int COORD_MAX_DEF   = 4095;

  localparam int COORD_W         = 12;
  localparam int COORD_FIELD_MAX = 4095;
  localparam int COLOUR_W        = 8;
  localparam int ROW_W           = 3;
  localparam int CELL            = 8;
  localparam logic [ROW_W-1:0] ROW_LAST = 3'd7;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // Input command codes (carried on the input tuser).
  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_BACK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_LOAD  = 2'd3;

  // Result kinds (carried on the output tuser).
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_FILL = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM = 3'd3;
  localparam logic [2:0] REG_INK    = 3'd4;
  localparam logic [2:0] REG_PAPER  = 3'd5;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WRAP  = 7'b0000010,
    S_CELL  = 7'b0000100,
    S_BACK  = 7'b0001000,
    S_START = 7'b0010000,
    S_ROWS  = 7'b0100000,
    S_FILL  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic             take;
    logic             newline;
    logic             clear;
    logic             load_glyph;
    logic             wrap;
    logic             back;
    logic             place;
    logic             cell_sel;
    logic [ROW_W-1:0] rd_row;
    logic             load_span;
    logic             load_fill;
    logic [ROW_W-1:0] row;
    logic             cur;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic corner;
    logic draw0;
    logic draw1;
    logic two;
    logic cell_end;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/tcgr_ctrl.sv
module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_code,
  output logic       in_ready,
  output cmd_t       cmd,
  input  status_t    stat
);

  state_t           state, state_next;
  logic             sel, sel_next;
  logic             cur, cur_next;
  logic [ROW_W-1:0] row, row_next;
  logic             more;

  assign in_ready = (state == S_IDLE);
  // A second cell of a tab follows the first one when the second cell is drawn.
  assign more = !cur && stat.two && stat.draw1;

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cur_next   = cur;
    row_next   = row;
    cmd        = '0;
    cmd.rd_row = row;
    cmd.row    = row;
    cmd.cur    = cur;
    cmd.cell_sel = sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          unique case (in_cmd)
            CMD_CHAR: begin
              if (in_code == CH_NEWLINE) begin
                cmd.newline = 1'b1;
              end else begin
                sel_next   = 1'b0;
                state_next = S_WRAP;
              end
            end
            CMD_BACK: begin
              sel_next   = 1'b0;
              state_next = S_BACK;
            end
            CMD_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_FILL;
            end
            CMD_LOAD: begin
              cmd.load_glyph = 1'b1;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WRAP: begin
        cmd.wrap   = 1'b1;
        state_next = S_CELL;
      end
      S_BACK: begin
        if (stat.corner) begin
          state_next = S_IDLE;
        end else begin
          cmd.back   = 1'b1;
          state_next = S_CELL;
        end
      end
      S_CELL: begin
        cmd.place = 1'b1;
        if (stat.two && !sel) begin
          sel_next   = 1'b1;
          state_next = S_WRAP;
        end else begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.rd_row = '0;
        row_next   = '0;
        if (stat.draw0) begin
          cur_next   = 1'b0;
          state_next = S_ROWS;
        end else if (stat.two && stat.draw1) begin
          cur_next   = 1'b1;
          state_next = S_ROWS;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ROWS: begin
        if (stat.out_free) begin
          cmd.load_span = 1'b1;
          cmd.last      = stat.cell_end && !more;
          if (stat.cell_end) begin
            row_next   = '0;
            cmd.rd_row = '0;
            if (more) begin
              cur_next = 1'b1;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            row_next   = row + 1'b1;
            cmd.rd_row = row + 1'b1;
          end
        end
      end
      S_FILL: begin
        if (stat.out_free) begin
          cmd.load_fill = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      cur   <= 1'b0;
      row   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      cur   <= cur_next;
      row   <= row_next;
    end
  end

endmodule

FILE: rtl/core/tcgr_dp.sv
module tcgr_dp
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_MAX   = COORD_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [COORD_W-1:0]  cfg_data,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_code,
  input  logic [ROW_W-1:0]    in_row,
  input  logic [7:0]          in_bits,
  input  cmd_t                cmd,
  output status_t             stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_kind,
  output logic [COORD_W-1:0]  out_x,
  output logic [COORD_W-1:0]  out_y,
  output logic [7:0]          out_pattern,
  output logic [COLOUR_W-1:0] out_fore,
  output logic [COLOUR_W-1:0] out_back,
  output logic [COORD_W-1:0]  out_width,
  output logic [COORD_W-1:0]  out_height,
  output logic                out_last
);

  localparam int CW    = ($clog2(COORD_MAX + 1) > COORD_W) ? $clog2(COORD_MAX + 1) : COORD_W;
  localparam int GW    = $clog2(GLYPH_COUNT);
  localparam int DEPTH = GLYPH_COUNT * CELL;
  localparam int LIMIT = (COORD_MAX < COORD_FIELD_MAX) ? COORD_MAX : COORD_FIELD_MAX;
  localparam logic [CW:0] MAXX   = (CW + 1)'(COORD_MAX);
  localparam logic [CW:0] LIMITX = (CW + 1)'(LIMIT);
  localparam logic [CW:0] CELLX  = (CW + 1)'(CELL);

  // Window and colour registers.
  logic [COORD_W-1:0]  win_left, win_top, win_right, win_bottom;
  logic [COLOUR_W-1:0] ink, paper;

  // Cursor and the cells prepared for one item.
  logic [CW-1:0] cur_x, cur_y, x_next, y_next;
  logic [CW-1:0] cell_x [2];
  logic [CW-1:0] cell_y [2];
  logic [1:0]    draw_q;
  logic [7:0]    code_q;
  logic          code_ok_q, two_q, blank_q;

  logic [7:0] glyph_mem [DEPTH];
  logic [7:0] rd_data;

  logic [CW:0]        x_e, y_e, left_x, top_x, right_x, bottom_x;
  logic               wrap_need, draw_now, in_code_ok;
  logic [COORD_W-1:0] span, fill_w, fill_h;
  logic               has_cell;
  logic [CW:0]        bs_raw;
  logic [CW-1:0]      bs_x;
  logic [CW:0]        y_row;
  logic [7:0]         code_eff;

  function automatic logic [CW-1:0] sat_add8(input logic [CW-1:0] v);
    logic [CW:0] s;
    s = {1'b0, v} + CELLX;
    return (s > MAXX) ? MAXX[CW-1:0] : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_sub8(input logic [CW-1:0] v);
    return (v >= CW'(CELL)) ? v - CW'(CELL) : '0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= COORD_W'(0);
      win_top    <= COORD_W'(0);
      win_right  <= COORD_W'(640);
      win_bottom <= COORD_W'(480);
      ink        <= COLOUR_W'(15);
      paper      <= COLOUR_W'(0);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEFT:   win_left   <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        REG_INK:    ink        <= cfg_data[COLOUR_W-1:0];
        REG_PAPER:  paper      <= cfg_data[COLOUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign x_e      = {1'b0, cur_x};
  assign y_e      = {1'b0, cur_y};
  assign left_x   = (CW + 1)'(win_left);
  assign top_x    = (CW + 1)'(win_top);
  assign right_x  = (CW + 1)'(win_right);
  assign bottom_x = (CW + 1)'(win_bottom);

  assign wrap_need = (x_e + CELLX) > right_x;

  // Backspace from the left edge lands on the last whole cell of the line.
  assign span     = win_right - win_left;
  assign has_cell = (win_right > win_left) && (span[COORD_W-1:3] != '0);
  assign bs_raw   = has_cell ? left_x + (CW + 1)'({span[COORD_W-1:3], 3'b000}) - CELLX
                             : left_x;
  assign bs_x     = (bs_raw > MAXX) ? MAXX[CW-1:0] : bs_raw[CW-1:0];

  assign draw_now = blank_q ? (y_e <= LIMITX)
                            : !((x_e < left_x) || ((x_e + CELLX) > right_x) ||
                                (y_e < top_x) || ((y_e + CELLX) > bottom_x));

  always_comb begin
    x_next = cur_x;
    y_next = cur_y;
    if (cmd.newline) begin
      y_next = sat_add8(cur_y);
      x_next = CW'(win_left);
    end else if (cmd.clear) begin
      x_next = CW'(win_left);
      y_next = CW'(win_top);
    end else if (cmd.wrap) begin
      if (wrap_need) begin
        y_next = sat_add8(cur_y);
        x_next = CW'(win_left);
      end
    end else if (cmd.back) begin
      if (x_e == left_x) begin
        y_next = sat_sub8(cur_y);
        x_next = bs_x;
      end else begin
        x_next = sat_sub8(cur_x);
      end
    end else if (cmd.place && !blank_q) begin
      x_next = sat_add8(cur_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
    end else begin
      cur_x <= x_next;
      cur_y <= y_next;
    end
  end

  assign code_eff   = (in_code == CH_TAB) ? CH_SPACE : in_code;
  assign in_code_ok = {1'b0, in_code} < 9'(GLYPH_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      code_q    <= code_eff;
      code_ok_q <= {1'b0, code_eff} < 9'(GLYPH_COUNT);
      two_q     <= (in_cmd == CMD_CHAR) && (in_code == CH_TAB);
      blank_q   <= (in_cmd == CMD_BACK);
    end
    if (cmd.place) begin
      cell_x[cmd.cell_sel] <= cur_x;
      cell_y[cmd.cell_sel] <= cur_y;
      draw_q[cmd.cell_sel] <= draw_now;
    end
  end

  // Glyph store: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load_glyph && in_code_ok) begin
      glyph_mem[{in_code[GW-1:0], in_row}] <= in_bits;
    end
    rd_data <= glyph_mem[{code_q[GW-1:0], cmd.rd_row}];
  end

  assign y_row = {1'b0, cell_y[cmd.cur]} + (CW + 1)'(cmd.row);

  assign fill_w = (win_right > win_left) ? win_right - win_left : '0;
  assign fill_h = (win_bottom > win_top) ? win_bottom - win_top : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_span || cmd.load_fill) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_span) begin
      out_kind    <= KIND_SPAN;
      out_x       <= cell_x[cmd.cur][COORD_W-1:0];
      out_y       <= y_row[COORD_W-1:0];
      out_pattern <= (blank_q || !code_ok_q) ? 8'h00 : rd_data;
      out_fore    <= ink;
      out_back    <= paper;
      out_width   <= COORD_W'(CELL);
      out_height  <= COORD_W'(1);
      out_last    <= cmd.last;
    end else if (cmd.load_fill) begin
      out_kind    <= KIND_FILL;
      out_x       <= win_left;
      out_y       <= win_top;
      out_pattern <= 8'h00;
      out_fore    <= ink;
      out_back    <= paper;
      out_width   <= fill_w;
      out_height  <= fill_h;
      out_last    <= 1'b1;
    end
  end

  assign stat.corner   = (x_e == left_x) && (y_e == top_x);
  assign stat.draw0    = draw_q[0];
  assign stat.draw1    = draw_q[1];
  assign stat.two      = two_q;
  assign stat.cell_end = (cmd.row == ROW_LAST) || (blank_q && (y_row == LIMITX));
  assign stat.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/core/text_cell_glyph_renderer_unit.sv
// A character or backspace yields up to eight span beats per drawn cell (a tab has two
// cells), a clear one fill beat, and a newline or glyph load no output. Throughput: the
// next input is taken once the last span or fill beat has entered the output register;
// span rows leave one per cycle unless the output stalls, set by the single glyph read port.
// Reset (rst, synchronous): cursor to (0,0), window 0,0..640,480, ink 15, paper 0, no
// output pending; the glyph store holds no defined contents until loaded.
module text_cell_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int COORD_MAX   = COORD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], font_row[10:8], font_bits[18:11]
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pos_x[11:0], pos_y[23:12], pattern[31:24], fore[39:32], back[47:40],
  // span_width[59:48], span_height[71:60]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,  // kind[0]
  output logic        m_axis_tlast
);

  cmd_t    cmd;
  status_t stat;

  assign cfg_ready = 1'b1;

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_code  (s_axis_tdata[7:0]),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tcgr_dp #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .COORD_MAX   (COORD_MAX)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_cmd      (s_axis_tuser),
    .in_code     (s_axis_tdata[7:0]),
    .in_row      (s_axis_tdata[10:8]),
    .in_bits     (s_axis_tdata[18:11]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_kind    (m_axis_tuser),
    .out_x       (m_axis_tdata[11:0]),
    .out_y       (m_axis_tdata[23:12]),
    .out_pattern (m_axis_tdata[31:24]),
    .out_fore    (m_axis_tdata[39:32]),
    .out_back    (m_axis_tdata[47:40]),
    .out_width   (m_axis_tdata[59:48]),
    .out_height  (m_axis_tdata[71:60]),
    .out_last    (m_axis_tlast)
  );

endmodule

FILE: rtl/core/tcgr_checker.sv
module tcgr_checker
  import tcgr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [11:0] cfg_data,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled output beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // Every span beat is one row of eight pixels.
  a_span_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_SPAN) |->
      (m_axis_tdata[59:48] == 12'd8) && (m_axis_tdata[71:60] == 12'd1))
    else $error("span beat with wrong width or height");

  // A clear yields exactly one fill beat, so it always closes its item and carries no pattern.
  a_fill_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_FILL) |->
      m_axis_tlast && (m_axis_tdata[31:24] == 8'h00))
    else $error("fill beat without last or with a pattern");

  // Only spans of a character or backspace continue past one beat.
  a_nonlast_span: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> (m_axis_tuser == KIND_SPAN))
    else $error("non-final beat is not a span");

endmodule

bind text_cell_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);
